### rtl/circle_raster_generator_assert.svh
// assertion macros shared by the circle raster generator modules
`ifndef CIRCLE_RASTER_GENERATOR_ASSERT_SVH
`define CIRCLE_RASTER_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circle raster check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circle raster check failed");

`endif

### rtl/crg_pkg.sv
// shared types and constants for the circle raster generator
`timescale 1ns / 1ps
`default_nettype none

package crg_pkg;

  // request commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // default output coordinate width
  localparam int COORD_BITS_DEF = 16;

  // job queue depth
  localparam int Q_DEPTH = 2;

  // index of the final result of a step
  localparam logic [2:0] FILL_LAST_IDX = 3'd3;
  localparam logic [2:0] OUTL_LAST_IDX = 3'd7;

  // one iteration handed from the front end to the span emitter
  typedef struct packed {
    logic signed [14:0] cx;
    logic signed [14:0] cy;
    logic signed [14:0] ox;
    logic signed [14:0] oy;
    logic               fill;
    logic               done;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/crg_front.sv
// front end: takes requests, holds circle state, runs one decision update per step
`timescale 1ns / 1ps
`default_nettype none

module crg_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic signed [14:0] in_center_x,
  input  wire logic signed [14:0] in_center_y,
  input  wire logic        [13:0] in_radius_in,
  input  wire logic               in_fill_mode,
  input  wire crg_pkg::q_stat_t   q_stat,
  output logic                    q_push,
  output crg_pkg::job_t           q_job
);
  import crg_pkg::*;

  logic signed [14:0] ox_r, ox_nxt;
  logic signed [14:0] oy_r, oy_nxt;
  logic signed [17:0] dec_r, dec_nxt;
  logic signed [14:0] cx_r, cx_nxt;
  logic signed [14:0] cy_r, cy_nxt;
  logic        [13:0] rad_r, rad_nxt;
  logic               fill_r, fill_nxt;
  logic               active_r, active_nxt;

  logic               acc;
  logic               step_go;
  logic signed [19:0] d_w, ox_w, oy_w, r_w;
  logic signed [19:0] two_ox, two_ro;
  logic signed [19:0] d_upd;
  logic signed [14:0] ox_upd, oy_upd;
  logic               done_upd;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign step_go  = acc && (in_cmd == CMD_STEP) && active_r;

  // widened operands for the decision test
  assign d_w    = {{2{dec_r[17]}}, dec_r};
  assign ox_w   = {{5{ox_r[14]}}, ox_r};
  assign oy_w   = {{5{oy_r[14]}}, oy_r};
  assign r_w    = {6'd0, rad_r};
  assign two_ox = ox_w <<< 1;
  assign two_ro = (r_w - oy_w) <<< 1;

  // three-way decision update
  always_comb begin
    if (d_w >= two_ox) begin
      d_upd  = d_w - two_ox - 20'sd1;
      ox_upd = ox_r + 15'sd1;
      oy_upd = oy_r;
    end else if (d_w < two_ro) begin
      d_upd  = d_w + (oy_w <<< 1) - 20'sd1;
      ox_upd = ox_r;
      oy_upd = oy_r - 15'sd1;
    end else begin
      d_upd  = d_w + ((oy_w - ox_w - 20'sd1) <<< 1);
      ox_upd = ox_r + 15'sd1;
      oy_upd = oy_r - 15'sd1;
    end
  end

  assign done_upd = oy_upd < ox_upd;

  // job for the emitter carries the offsets before the update
  assign q_push      = step_go;
  assign q_job.cx    = cx_r;
  assign q_job.cy    = cy_r;
  assign q_job.ox    = ox_r;
  assign q_job.oy    = oy_r;
  assign q_job.fill  = fill_r;
  assign q_job.done  = done_upd;

  // state next values
  always_comb begin
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    dec_nxt    = dec_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    fill_nxt   = fill_r;
    active_nxt = active_r;
    if (acc && (in_cmd == CMD_START)) begin
      cx_nxt     = in_center_x;
      cy_nxt     = in_center_y;
      rad_nxt    = in_radius_in;
      fill_nxt   = in_fill_mode;
      ox_nxt     = '0;
      oy_nxt     = {1'b0, in_radius_in};
      dec_nxt    = {4'd0, in_radius_in} - 18'sd1;
      active_nxt = 1'b1;
    end else if (step_go) begin
      ox_nxt     = ox_upd;
      oy_nxt     = oy_upd;
      dec_nxt    = d_upd[17:0];
      active_nxt = !done_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else begin
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      dec_r    <= dec_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      rad_r    <= rad_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
    end
  end

`include "circle_raster_generator_assert.svh"

  // the step that ends the circle leaves the front idle
  `CRG_ASSERT_NEXT(a_done_goes_idle, step_go && done_upd, !active_r)
  // a start always leaves the front active with x offset cleared
  `CRG_ASSERT_NEXT(a_start_arms, acc && (in_cmd == CMD_START), active_r && (ox_r == 15'sd0))

endmodule

`default_nettype wire

### rtl/crg_job_fifo.sv
// short job queue between the front end and the span emitter
`timescale 1ns / 1ps
`default_nettype none

module crg_job_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire crg_pkg::job_t    push_job,
  input  wire logic             pop,
  output crg_pkg::job_t         head_job,
  output crg_pkg::q_stat_t      stat
);
  import crg_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign head_job   = mem_r[rd_ptr_r];

  // pointer and count bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`include "circle_raster_generator_assert.svh"

  // no write into a full queue
  `CRG_ASSERT_NOW(a_no_overflow, push, !stat.full)
  // no read from an empty queue
  `CRG_ASSERT_NOW(a_no_underflow, pop, !stat.empty)

endmodule

`default_nettype wire

### rtl/crg_emit.sv
// span emitter: walks a job's mirrored points or spans into the output register
`timescale 1ns / 1ps
`default_nettype none

module crg_emit #(
  parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire crg_pkg::job_t                job,
  input  wire crg_pkg::q_stat_t             q_stat,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_span_x_start,
  output logic signed [COORD_BITS-1:0]      out_span_x_end,
  output logic signed [COORD_BITS-1:0]      out_span_y,
  output logic                              out_last_of_step,
  output logic                              out_circle_done
);
  import crg_pkg::*;

  localparam int SUM_W = (COORD_BITS > 17) ? COORD_BITS : 17;

  logic [2:0]                   idx_r, idx_nxt;
  logic                         vld_r, vld_nxt;
  logic signed [COORD_BITS-1:0] xs_r, xe_r, y_r;
  logic                         last_r, done_r;

  logic                         load;
  logic                         last_idx;
  logic signed [COORD_BITS-1:0] xs_c, xe_c, y_c;
  logic signed [COORD_BITS-1:0] cx_pox, cx_mox, cx_poy, cx_moy;
  logic signed [COORD_BITS-1:0] cy_pox, cy_mox, cy_poy, cy_moy;

  // wrapped center plus or minus offset
  function automatic logic [COORD_BITS-1:0] csum(input logic signed [14:0] a,
                                                 input logic signed [14:0] b,
                                                 input logic sub);
    logic signed [SUM_W-1:0] ae;
    logic signed [SUM_W-1:0] be;
    logic signed [SUM_W-1:0] s;
    ae = {{(SUM_W-15){a[14]}}, a};
    be = {{(SUM_W-15){b[14]}}, b};
    s  = sub ? (ae - be) : (ae + be);
    return s[COORD_BITS-1:0];
  endfunction

  assign cx_pox = csum(job.cx, job.ox, 1'b0);
  assign cx_mox = csum(job.cx, job.ox, 1'b1);
  assign cx_poy = csum(job.cx, job.oy, 1'b0);
  assign cx_moy = csum(job.cx, job.oy, 1'b1);
  assign cy_pox = csum(job.cy, job.ox, 1'b0);
  assign cy_mox = csum(job.cy, job.ox, 1'b1);
  assign cy_poy = csum(job.cy, job.oy, 1'b0);
  assign cy_moy = csum(job.cy, job.oy, 1'b1);

  // pick the result for the current index
  always_comb begin
    xs_c = cx_pox;
    xe_c = cx_pox;
    y_c  = cy_poy;
    if (job.fill) begin
      unique case (idx_r[1:0])
        2'd0: begin xs_c = cx_moy; xe_c = cx_poy; y_c = cy_pox; end
        2'd1: begin xs_c = cx_mox; xe_c = cx_pox; y_c = cy_poy; end
        2'd2: begin xs_c = cx_mox; xe_c = cx_pox; y_c = cy_moy; end
        2'd3: begin xs_c = cx_moy; xe_c = cx_poy; y_c = cy_mox; end
        default: begin xs_c = cx_moy; xe_c = cx_poy; y_c = cy_pox; end
      endcase
    end else begin
      unique case (idx_r)
        3'd0: begin xs_c = cx_pox; y_c = cy_poy; end
        3'd1: begin xs_c = cx_poy; y_c = cy_pox; end
        3'd2: begin xs_c = cx_mox; y_c = cy_poy; end
        3'd3: begin xs_c = cx_moy; y_c = cy_pox; end
        3'd4: begin xs_c = cx_pox; y_c = cy_moy; end
        3'd5: begin xs_c = cx_poy; y_c = cy_mox; end
        3'd6: begin xs_c = cx_mox; y_c = cy_moy; end
        3'd7: begin xs_c = cx_moy; y_c = cy_mox; end
        default: begin xs_c = cx_pox; y_c = cy_poy; end
      endcase
      xe_c = xs_c;
    end
  end

  assign last_idx = job.fill ? (idx_r == FILL_LAST_IDX) : (idx_r == OUTL_LAST_IDX);
  assign load     = !q_stat.empty && (!vld_r || out_ready);
  assign q_pop    = load && last_idx;

  // index and output valid control
  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_idx ? 3'd0 : idx_r + 3'd1;
    end
    vld_nxt = load || (vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      xs_r   <= xs_c;
      xe_r   <= xe_c;
      y_r    <= y_c;
      last_r <= last_idx;
      done_r <= last_idx && job.done;
    end
  end

  assign out_valid        = vld_r;
  assign out_span_x_start = xs_r;
  assign out_span_x_end   = xe_r;
  assign out_span_y       = y_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

`include "circle_raster_generator_assert.svh"

  // circle end is only flagged on the final result of a step
  `CRG_ASSERT_NOW(a_done_on_last, vld_r && done_r, last_r)
  // a fill job never walks past its fourth span
  `CRG_ASSERT_NOW(a_fill_idx, !q_stat.empty && job.fill, idx_r <= FILL_LAST_IDX)

endmodule

`default_nettype wire

### rtl/circle_raster_generator.sv
// top level of the circle raster generator
`timescale 1ns / 1ps
`default_nettype none

// Integer circle rasterizer (Andres scheme). A start request (cmd = 0) loads
// center, radius and outline/fill choice and gives no result; a step
// request (cmd = 1) runs one iteration and yields eight mirrored points
// (outline) or four horizontal spans (fill), the last one flagged with
// last_of_step and, on the iteration that ends the circle, circle_done. Steps
// while no circle is running are taken and dropped. The front end accepts a
// request every cycle while its two-entry job queue has room; the span
// emitter drives one result per cycle while out_ready is high, through a
// registered output, so a sustained stream of steps is bounded by that
// single output port. With the queue empty, a step's job is first written
// into the job queue and its first result is then loaded into the output
// register. Output coordinates wrap to COORD_BITS two's complement.
module circle_raster_generator #(
  parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_cmd,
  input  wire logic signed [14:0]      in_center_x,
  input  wire logic signed [14:0]      in_center_y,
  input  wire logic        [13:0]      in_radius_in,
  input  wire logic                    in_fill_mode,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [COORD_BITS-1:0] out_span_x_start,
  output logic signed [COORD_BITS-1:0] out_span_x_end,
  output logic signed [COORD_BITS-1:0] out_span_y,
  output logic                         out_last_of_step,
  output logic                         out_circle_done
);
  import crg_pkg::*;

  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  // request intake and decision update
  crg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius_in (in_radius_in),
    .in_fill_mode (in_fill_mode),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // job queue
  crg_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // point and span output
  crg_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job              (head_job),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x_start (out_span_x_start),
    .out_span_x_end   (out_span_x_end),
    .out_span_y       (out_span_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

endmodule

`default_nettype wire

### verif/circle_span_checker.sv
// checker for the circle raster generator: predicts the points and spans and compares them
`timescale 1ns / 1ps

module circle_span_checker #(
  parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic                    in_cmd,
  input  wire logic signed [14:0]      in_center_x,
  input  wire logic signed [14:0]      in_center_y,
  input  wire logic        [13:0]      in_radius_in,
  input  wire logic                    in_fill_mode,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic signed [COORD_BITS-1:0] out_span_x_start,
  input  wire logic signed [COORD_BITS-1:0] out_span_x_end,
  input  wire logic signed [COORD_BITS-1:0] out_span_y,
  input  wire logic                    out_last_of_step,
  input  wire logic                    out_circle_done,
  output int                           span_errors,
  output int                           spans_pending
);
  import crg_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         done;
  } span_t;

  // spans still owed by the block, oldest first
  span_t pending_spans[$];

  // shadow of the rasterizer state
  logic signed [14:0] off_x;
  logic signed [14:0] off_y;
  logic signed [17:0] decision;
  logic signed [14:0] ctr_x;
  logic signed [14:0] ctr_y;
  logic        [13:0] rad;
  logic               fill_on;
  logic               running;

  initial begin
    span_errors = 0;
    spans_pending = 0;
  end

  function automatic span_t make_span(int xs, int xe, int yv);
    span_t s;
    s.x_start = COORD_BITS'(xs);
    s.x_end   = COORD_BITS'(xe);
    s.y       = COORD_BITS'(yv);
    s.last    = 1'b0;
    s.done    = 1'b0;
    return s;
  endfunction

  task automatic report_mismatch(string what, int want, int seen);
    span_errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
  endtask

  // latch a new circle; any running one is dropped
  task automatic begin_circle();
    int r;
    r = in_radius_in;
    ctr_x    = in_center_x;
    ctr_y    = in_center_y;
    rad      = in_radius_in;
    fill_on  = in_fill_mode;
    off_x    = '0;
    off_y    = 15'(r);
    decision = 18'(r - 1);
    running  = 1'b1;
  endtask

  // one iteration: emit mirrored points or spans, then move the decision value
  task automatic raster_iteration();
    span_t spans[8];
    int n, cx, cy, ox, oy, d, r;
    cx = ctr_x;
    cy = ctr_y;
    ox = off_x;
    oy = off_y;
    d  = decision;
    r  = rad;
    if (fill_on) begin
      spans[0] = make_span(cx - oy, cx + oy, cy + ox);
      spans[1] = make_span(cx - ox, cx + ox, cy + oy);
      spans[2] = make_span(cx - ox, cx + ox, cy - oy);
      spans[3] = make_span(cx - oy, cx + oy, cy - ox);
      n = 4;
    end else begin
      spans[0] = make_span(cx + ox, cx + ox, cy + oy);
      spans[1] = make_span(cx + oy, cx + oy, cy + ox);
      spans[2] = make_span(cx - ox, cx - ox, cy + oy);
      spans[3] = make_span(cx - oy, cx - oy, cy + ox);
      spans[4] = make_span(cx + ox, cx + ox, cy - oy);
      spans[5] = make_span(cx + oy, cx + oy, cy - ox);
      spans[6] = make_span(cx - ox, cx - ox, cy - oy);
      spans[7] = make_span(cx - oy, cx - oy, cy - ox);
      n = 8;
    end
    // three-way decision update
    if (d >= 2 * ox) begin
      d = d - (2 * ox + 1);
      ox = ox + 1;
    end else if (d < 2 * (r - oy)) begin
      d = d + 2 * oy - 1;
      oy = oy - 1;
    end else begin
      d = d + 2 * (oy - ox - 1);
      oy = oy - 1;
      ox = ox + 1;
    end
    off_x    = 15'(ox);
    off_y    = 15'(oy);
    decision = 18'(d);
    spans[n-1].last = 1'b1;
    if (off_y < off_x) begin
      running = 1'b0;
      spans[n-1].done = 1'b1;
    end
    for (int k = 0; k < n; k++)
      pending_spans.push_back(spans[k]);
  endtask

  task automatic check_span();
    span_t want;
    if (pending_spans.size() == 0) begin
      report_mismatch("unexpected result, x_start", 0, out_span_x_start);
    end else begin
      want = pending_spans.pop_front();
      if (out_span_x_start !== want.x_start)
        report_mismatch("span_x_start", want.x_start, out_span_x_start);
      if (out_span_x_end !== want.x_end)
        report_mismatch("span_x_end", want.x_end, out_span_x_end);
      if (out_span_y !== want.y)
        report_mismatch("span_y", want.y, out_span_y);
      if (out_last_of_step !== want.last)
        report_mismatch("last_of_step", want.last, out_last_of_step);
      if (out_circle_done !== want.done)
        report_mismatch("circle_done", want.done, out_circle_done);
    end
  endtask

  // watch both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      off_x    = '0;
      off_y    = '0;
      decision = '0;
      ctr_x    = '0;
      ctr_y    = '0;
      rad      = '0;
      fill_on  = 1'b0;
      running  = 1'b0;
      pending_spans.delete();
    end else begin
      if (out_valid && out_ready)
        check_span();
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_START)
          begin_circle();
        else if (running)
          raster_iteration();
      end
    end
    spans_pending = pending_spans.size();
  end

endmodule

### verif/tb.sv
// top of the circle raster generator testbench: clock, reset, requests and verdict
`timescale 1ns / 1ps

module tb;
  import crg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 280;
  localparam logic signed [14:0] CTR_MIN = 15'h4000;
  localparam logic signed [14:0] CTR_MAX = 15'h3fff;
  localparam logic        [13:0] RAD_MAX = 14'h3fff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_START;
  logic signed [14:0] in_center_x = '0;
  logic signed [14:0] in_center_y = '0;
  logic        [13:0] in_radius_in = '0;
  logic in_fill_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_BITS_DEF-1:0] out_span_x_start;
  logic signed [COORD_BITS_DEF-1:0] out_span_x_end;
  logic signed [COORD_BITS_DEF-1:0] out_span_y;
  logic out_last_of_step;
  logic out_circle_done;

  int span_errors;
  int spans_pending;
  int cycles = 0;
  int items_sent = 0;
  int sink_stall = 0;
  logic res_taken = 1'b0;
  logic src_steady = 1'b0;
  logic sink_steady = 1'b0;

  circle_raster_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius_in     (in_radius_in),
    .in_fill_mode     (in_fill_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x_start (out_span_x_start),
    .out_span_x_end   (out_span_x_end),
    .out_span_y       (out_span_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

  circle_span_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius_in     (in_radius_in),
    .in_fill_mode     (in_fill_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x_start (out_span_x_start),
    .out_span_x_end   (out_span_x_end),
    .out_span_y       (out_span_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done),
    .span_errors      (span_errors),
    .spans_pending    (spans_pending)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall after each taken result, with stretches of none
  always @(posedge clk) res_taken <= out_valid && out_ready;

  always @(negedge clk) begin
    if (res_taken) begin
      if ($urandom_range(0, 39) == 0)
        sink_steady = !sink_steady;
      sink_stall = sink_steady ? 0 : $urandom_range(0, 10);
    end
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // drive one request after a random gap; called and returns at a falling edge
  task automatic send_request(input logic cmd, input logic signed [14:0] cx,
                              input logic signed [14:0] cy, input logic [13:0] rad,
                              input logic fill);
    int gap;
    if ($urandom_range(0, 29) == 0)
      src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_cmd       = cmd;
    in_center_x  = cx;
    in_center_y  = cy;
    in_radius_in = rad;
    in_fill_mode = fill;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // step request; the other fields carry noise
  task automatic step_once();
    send_request(CMD_STEP, 15'($urandom), 15'($urandom), 14'($urandom), 1'($urandom));
  endtask

  initial begin
    int pick, steps;
    logic signed [14:0] cx, cy;
    logic [13:0] rad;
    logic fill;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: step while idle, zero radius at the corners, max radius,
    // restart while running, tiny circles to completion
    step_once();
    send_request(CMD_START, CTR_MIN, CTR_MAX, 14'd0, 1'b0);
    step_once();
    step_once();
    send_request(CMD_START, CTR_MAX, CTR_MIN, 14'd0, 1'b1);
    step_once();
    send_request(CMD_START, CTR_MAX, CTR_MAX, RAD_MAX, 1'b0);
    repeat (3) step_once();
    send_request(CMD_START, CTR_MIN, CTR_MIN, RAD_MAX, 1'b1);
    repeat (2) step_once();
    send_request(CMD_START, CTR_MIN, CTR_MIN, 14'd1, 1'b1);
    repeat (2) step_once();
    send_request(CMD_START, '0, '0, 14'd3, 1'b0);
    repeat (4) step_once();

    // random circles, mostly run to the end, some cut short or huge
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      cx   = 15'($urandom);
      cy   = 15'($urandom);
      fill = 1'($urandom);
      if (pick == 0) begin
        rad   = 14'($urandom);
        steps = $urandom_range(1, 4);
      end else if (pick < 3) begin
        rad   = '0;
        steps = 1;
      end else begin
        rad   = 14'($urandom_range(1, 24));
        steps = (rad * 3) / 4 + 3;
        if ($urandom_range(0, 7) == 0)
          steps = $urandom_range(1, steps);
      end
      if (pick == 19)
        step_once();
      send_request(CMD_START, cx, cy, rad, fill);
      repeat (steps) step_once();
    end
    in_valid = 1'b0;

    // drain, then allow for the output pipeline
    while (spans_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (span_errors == 0 && spans_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/crg_pkg.sv
rtl/crg_front.sv
rtl/crg_job_fifo.sv
rtl/crg_emit.sv
rtl/circle_raster_generator.sv
verif/circle_span_checker.sv
verif/tb.sv
